### rtl/sef_pkg.sv
// Shared types, constants and the kernel function of the Sobel edge filter.
`timescale 1ns / 1ps

package sef_pkg;

    // Default line store depth (pixels per row).
    localparam int MAX_WIDTH_DEF = 512;

    // Register field widths and reset values
    localparam int WIDTH_W      = 10;
    localparam int ROW_W        = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int WIDTH_RESET  = 512;
    localparam int HEIGHT_RESET = 512;
    localparam int HEIGHT_LIMIT = 4096;

    // Offset added to the kernel sum.
    localparam int EDGE_OFFSET = 128;

    // Result queue; depth must be a power of two so pointers wrap naturally.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIRECTION = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } sef_cfg_index_t;

    // Input transaction kinds
    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } sef_action_t;

    // Gradient direction codes
    localparam logic DIR_HORIZONTAL = 1'b0;
    localparam logic DIR_VERTICAL   = 1'b1;

    typedef struct packed {
        sef_action_t action;
        logic [7:0]  pixel;
    } sef_in_t;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       last_in_run;
        logic       frame_end;
    } sef_out_t;

    // Write-back request for the entry read in the previous cycle.
    typedef struct packed {
        logic       newer_en;
        logic       older_en;
        logic [7:0] pix;
    } sef_wr_ctl_t;

    // Per-transaction control carried from acceptance to the window stage.
    typedef struct packed {
        logic       wr_newer;
        logic       wr_older;
        logic       load;
        logic       second_row;
        logic       flush;
        logic       col0;
        logic       emit_a;
        logic       emit_b;
        logic       frame_end;
        logic       dir;
        logic [7:0] pix;
    } sef_col_ctl_t;

    // Up to two results pushed into the queue in one cycle.
    typedef struct packed {
        logic     push_a;
        logic     push_b;
        sef_out_t res_a;
        sef_out_t res_b;
    } sef_push_t;

    // 3x3 window, indexed [row][column].
    typedef logic [2:0][2:0][7:0] sef_window_t;

    // Kernel sum plus offset, saturated to 0..255.
    function automatic logic [7:0] sef_edge(input sef_window_t w, input logic dir);
        logic [9:0]         pos;
        logic [9:0]         neg;
        logic signed [11:0] s;
        if (dir == DIR_HORIZONTAL) begin
            pos = {2'b00, w[0][2]} + {1'b0, w[1][2], 1'b0} + {2'b00, w[2][2]};
            neg = {2'b00, w[0][0]} + {1'b0, w[1][0], 1'b0} + {2'b00, w[2][0]};
        end else begin
            pos = {2'b00, w[2][0]} + {1'b0, w[2][1], 1'b0} + {2'b00, w[2][2]};
            neg = {2'b00, w[0][0]} + {1'b0, w[0][1], 1'b0} + {2'b00, w[0][2]};
        end
        s = $signed({2'b00, pos}) - $signed({2'b00, neg}) + 12'(EDGE_OFFSET);
        if (s < 12'sd0) begin
            return 8'd0;
        end else if (s > 12'sd255) begin
            return 8'd255;
        end else begin
            return s[7:0];
        end
    endfunction

endpackage

### rtl/sobel_edge_filter_3x3_unit.sv
// Top level of the 3x3 Sobel edge filter: registers, counters and flow control.
`timescale 1ns / 1ps

// The filter takes one pixel or flush transaction per clock and sustains that
// rate as long as the result side takes one result per clock. Each
// transaction goes through three stages: acceptance issues a read of both row
// memories (one read and one write port each), the next cycle writes the
// column back and loads the 3x3 window, and the third stage forms the kernel
// results from the registered window and queues them, and a result is offered
// once the queue holds it. The last column of a row yields two results,
// the first column none; an 8-entry result queue with reservation of queued
// and in-flight results sets s_ready. Results of row r appear while row r+1
// arrives; after the last row, frame_width flush transactions drain it. The
// row memories need no clearing after reset.
module sobel_edge_filter_3x3_unit #(
    parameter int MAX_WIDTH = sef_pkg::MAX_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sef_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sef_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sef_pkg::sef_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sef_pkg::sef_out_t                   m_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = sef_pkg::ROW_W;
    localparam int CNT_W = sef_pkg::FIFO_CNT_W;
    localparam logic [ROW_W-1:0] MAX_W13 = ROW_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] H_LIMIT = ROW_W'(sef_pkg::HEIGHT_LIMIT);

    // Configuration registers
    logic                        dir_reg;
    logic                        dir_next;
    logic [sef_pkg::WIDTH_W-1:0] width_reg;
    logic [sef_pkg::WIDTH_W-1:0] width_next;
    logic [ROW_W-1:0]            height_reg;
    logic [ROW_W-1:0]            height_next;

    // Position counters
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] flush_reg;
    logic [COL_W-1:0] flush_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    sef_pkg::sef_col_ctl_t ctl_reg;
    sef_pkg::sef_col_ctl_t ctl_next;
    sef_pkg::sef_wr_ctl_t  wr_ctl;
    sef_pkg::sef_push_t    push;

    logic [ROW_W-1:0] width13;
    logic [ROW_W-1:0] last13;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] h_use;
    logic [COL_W-1:0] c_pix;
    logic [COL_W-1:0] c_fl;
    logic [COL_W-1:0] c_sel;
    logic             rows_in;
    logic             accept;
    logic             do_pix;
    logic             do_fl;
    logic             at_last;
    logic [1:0]       n_acc;
    logic [1:0]       n_push;
    logic [CNT_W-1:0] q_count;
    logic [CNT_W:0]   reserved;

    // Configuration writes
    always_comb begin
        dir_next    = dir_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                sef_pkg::CFG_DIRECTION: dir_next    = cfg_wdata[0];
                sef_pkg::CFG_WIDTH:     width_next  = cfg_wdata[sef_pkg::WIDTH_W-1:0];
                sef_pkg::CFG_HEIGHT:    height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the frame size to its usable range
    always_comb begin
        width13 = {{(ROW_W - sef_pkg::WIDTH_W){1'b0}}, width_reg};
        if (width_reg < sef_pkg::WIDTH_W'(2)) begin
            last13 = ROW_W'(1);
        end else if (width13 > MAX_W13) begin
            last13 = MAX_W13 - ROW_W'(1);
        end else begin
            last13 = width13 - ROW_W'(1);
        end
        last_col = last13[COL_W-1:0];
        if (height_reg < ROW_W'(2)) begin
            h_use = ROW_W'(2);
        end else if (height_reg > H_LIMIT) begin
            h_use = H_LIMIT;
        end else begin
            h_use = height_reg;
        end
    end

    // Decode the transaction and update the counters
    assign accept  = s_valid && s_ready;
    assign rows_in = (row_reg >= h_use);
    assign do_pix  = accept && (s_data.action == sef_pkg::ACT_PIXEL) && !rows_in;
    assign do_fl   = accept && (s_data.action == sef_pkg::ACT_FLUSH) && rows_in;
    assign c_pix   = (col_reg > last_col) ? last_col : col_reg;
    assign c_fl    = (flush_reg > last_col) ? last_col : flush_reg;
    assign c_sel   = (s_data.action == sef_pkg::ACT_FLUSH) ? c_fl : c_pix;
    assign at_last = (c_sel == last_col);

    always_comb begin
        col_next   = col_reg;
        flush_next = flush_reg;
        row_next   = row_reg;
        ctl_next   = '0;
        if (do_pix) begin
            ctl_next.wr_newer   = 1'b1;
            ctl_next.wr_older   = (row_reg != '0);
            ctl_next.load       = (row_reg != '0);
            ctl_next.second_row = (row_reg == ROW_W'(1));
            ctl_next.emit_a     = (row_reg != '0) && (c_sel != '0);
            ctl_next.emit_b     = (row_reg != '0) && at_last;
            if (at_last) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = c_sel + COL_W'(1);
            end
        end else if (do_fl) begin
            ctl_next.load      = 1'b1;
            ctl_next.flush     = 1'b1;
            ctl_next.emit_a    = (c_sel != '0);
            ctl_next.emit_b    = at_last;
            ctl_next.frame_end = at_last;
            if (at_last) begin
                col_next   = '0;
                flush_next = '0;
                row_next   = '0;
            end else begin
                flush_next = c_sel + COL_W'(1);
            end
        end
        ctl_next.col0 = (c_sel == '0);
        ctl_next.dir  = dir_reg;
        ctl_next.pix  = s_data.pixel;
    end

    // Reserve queue space for every result still in flight
    assign n_acc         = {1'b0, ctl_next.emit_a} + {1'b0, ctl_next.emit_b};
    assign n_push        = {1'b0, push.push_a} + {1'b0, push.push_b};
    assign inflight_next = inflight_reg + CNT_W'(n_acc) - CNT_W'(n_push);
    assign reserved      = {1'b0, q_count} + {1'b0, inflight_reg};
    assign s_ready       = (reserved <= (CNT_W + 1)'(sef_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg      <= sef_pkg::DIR_HORIZONTAL;
            width_reg    <= sef_pkg::WIDTH_W'(sef_pkg::WIDTH_RESET);
            height_reg   <= ROW_W'(sef_pkg::HEIGHT_RESET);
            col_reg      <= '0;
            flush_reg    <= '0;
            row_reg      <= '0;
            inflight_reg <= '0;
            ctl_reg      <= '0;
        end else begin
            dir_reg      <= dir_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            flush_reg    <= flush_next;
            row_reg      <= row_next;
            inflight_reg <= inflight_next;
            ctl_reg      <= ctl_next;
        end
    end

    // Write back the column read in the previous cycle
    always_comb begin
        wr_ctl.newer_en = ctl_reg.wr_newer;
        wr_ctl.older_en = ctl_reg.wr_older;
        wr_ctl.pix      = ctl_reg.pix;
    end

    logic [7:0] newer_rd;
    logic [7:0] older_rd;

    sef_line_store #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (do_pix || do_fl),
        .rd_addr (c_sel),
        .wr_ctl  (wr_ctl),
        .newer_rd(newer_rd),
        .older_rd(older_rd)
    );

    sef_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl_reg),
        .newer_rd(newer_rd),
        .older_rd(older_rd),
        .push    (push)
    );

    sef_result_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .count   (q_count)
    );

endmodule

### rtl/sef_line_store.sv
// Two row memories with registered read and read-modify-write of the entry just read.
`timescale 1ns / 1ps

module sef_line_store #(
    parameter int MAX_WIDTH = sef_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    input  sef_pkg::sef_wr_ctl_t  wr_ctl,
    output logic [7:0]            newer_rd,
    output logic [7:0]            older_rd
);

    logic [7:0]        newer_mem [MAX_WIDTH];
    logic [7:0]        older_mem [MAX_WIDTH];
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        newer_rd_reg;
    logic [7:0]        older_rd_reg;

    // Read both rows and remember the column for write-back
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            newer_rd_reg <= newer_mem[rd_addr];
            older_rd_reg <= older_mem[rd_addr];
            addr_reg     <= rd_addr;
        end
    end

    // Write back: advance the newer pixel into the older row, store the new pixel
    always_ff @(posedge aclk) begin
        if (wr_ctl.newer_en) begin
            newer_mem[addr_reg] <= wr_ctl.pix;
        end
        if (wr_ctl.older_en) begin
            older_mem[addr_reg] <= newer_rd_reg;
        end
    end

    assign newer_rd = newer_rd_reg;
    assign older_rd = older_rd_reg;

endmodule

### rtl/sef_window.sv
// 3x3 window register and the kernel stage that forms up to two results.
`timescale 1ns / 1ps

module sef_window (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sef_pkg::sef_col_ctl_t ctl,
    input  logic [7:0]            newer_rd,
    input  logic [7:0]            older_rd,
    output sef_pkg::sef_push_t    push
);

    typedef struct packed {
        logic emit_a;
        logic emit_b;
        logic frame_end;
        logic dir;
    } sef_stage_t;

    sef_pkg::sef_window_t window_reg;
    sef_pkg::sef_window_t window_next;
    sef_pkg::sef_window_t shifted;
    sef_stage_t           stage_reg;
    sef_stage_t           stage_next;
    logic [2:0][7:0]      column;

    // Build the new right column with top and bottom replication
    always_comb begin
        column[1] = newer_rd;
        column[0] = ctl.second_row ? newer_rd : older_rd;
        column[2] = ctl.flush ? newer_rd : ctl.pix;
    end

    // Shift the window left, or fill it entirely at the first column
    always_comb begin
        window_next = window_reg;
        stage_next  = '0;
        if (ctl.load) begin
            for (int r = 0; r < 3; r++) begin
                if (ctl.col0) begin
                    window_next[r][0] = column[r];
                    window_next[r][1] = column[r];
                end else begin
                    window_next[r][0] = window_reg[r][1];
                    window_next[r][1] = window_reg[r][2];
                end
                window_next[r][2] = column[r];
            end
            stage_next.emit_a    = ctl.emit_a;
            stage_next.emit_b    = ctl.emit_b;
            stage_next.frame_end = ctl.frame_end;
            stage_next.dir       = ctl.dir;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            stage_reg  <= '0;
        end else begin
            window_reg <= window_next;
            stage_reg  <= stage_next;
        end
    end

    // Right replication for the extra result at the end of a row
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            shifted[r][0] = window_reg[r][1];
            shifted[r][1] = window_reg[r][2];
            shifted[r][2] = window_reg[r][2];
        end
    end

    // Form the results
    always_comb begin
        push.push_a            = stage_reg.emit_a;
        push.push_b            = stage_reg.emit_b;
        push.res_a.edge_value  = sef_pkg::sef_edge(window_reg, stage_reg.dir);
        push.res_a.last_in_run = !stage_reg.emit_b;
        push.res_a.frame_end   = 1'b0;
        push.res_b.edge_value  = sef_pkg::sef_edge(shifted, stage_reg.dir);
        push.res_b.last_in_run = 1'b1;
        push.res_b.frame_end   = stage_reg.frame_end;
    end

endmodule

### rtl/sef_result_fifo.sv
// Result queue taking up to two results per cycle and giving one while m_ready is high.
`timescale 1ns / 1ps

module sef_result_fifo (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sef_pkg::sef_push_t                 push,
    input  logic                               m_ready,
    output logic                               m_valid,
    output sef_pkg::sef_out_t                  m_data,
    output logic [sef_pkg::FIFO_CNT_W-1:0]     count
);

    localparam int PTR_W = sef_pkg::FIFO_PTR_W;
    localparam int CNT_W = sef_pkg::FIFO_CNT_W;

    sef_pkg::sef_out_t entry_reg [sef_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [1:0]        n_push;
    logic [PTR_W-1:0]  b_ptr;
    logic              pop;

    assign pop    = m_valid && m_ready;
    assign n_push = {1'b0, push.push_a} + {1'b0, push.push_b};
    assign b_ptr  = push.push_a ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the results in arrival order
    always_ff @(posedge aclk) begin
        if (push.push_a) begin
            entry_reg[wr_ptr_reg] <= push.res_a;
        end
        if (push.push_b) begin
            entry_reg[b_ptr] <= push.res_b;
        end
    end

    assign m_valid = (count_reg != '0);
    assign m_data  = entry_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

### rtl/sef_checker.sv
// Port-level assertions for the Sobel edge filter, bound to the top level.
`timescale 1ns / 1ps

module sef_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input sef_pkg::sef_out_t m_data
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // Drop all results on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // The frame end is always the last result of its transaction
    a_fend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |-> m_data.last_in_run)
        else $error("frame end without last_in_run");

    // A newly visible result must follow an accepted input transaction
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 3))
        else $error("result appeared without a matching transaction");

endmodule

bind sobel_edge_filter_3x3_unit sef_checker u_sef_checker (.*);
